>>> hdl/q41dq_pkg.sv
// ----------------------------------------------------------------------------
// q41dq_pkg
// Shared types, constants and helpers of the Q4_1 block dequantizer.
// ----------------------------------------------------------------------------
package q41dq_pkg;

  // Finite halves as integers in units of 2^-24.
  localparam int unsigned MagW  = 40;
  localparam int unsigned ProdW = 44;
  localparam int unsigned SumW  = 45;
  localparam int unsigned LeadW = 6;

  localparam logic [31:0] DefaultNan = 32'hFFC0_0000;
  localparam logic [7:0]  ExpOffset  = 8'd103;
  localparam logic [1:0]  LastGroup  = 2'd3;
  localparam logic [3:0]  NibMask    = 4'hF;

  typedef struct packed {
    logic [15:0] scale_half;
    logic [15:0] min_half;
    logic [63:0] quants_front;
    logic [63:0] quants_back;
    logic        row_end;
  } in_t;

  typedef struct packed {
    logic [31:0] value0;
    logic [31:0] value1;
    logic [31:0] value2;
    logic [31:0] value3;
    logic [31:0] value4;
    logic [31:0] value5;
    logic [31:0] value6;
    logic [31:0] value7;
    logic [1:0]  group_index;
    logic        block_done;
    logic        row_done;
  } out_t;

  typedef struct packed {
    logic            sign;
    logic            nan;
    logic            inf;
    logic [9:0]      pay;
    logic [MagW-1:0] mag;
  } half_t;

  typedef struct packed {
    half_t s;
    half_t m;
  } opnd_t;

  typedef struct packed {
    logic [1:0] grp;
    logic       row;
  } ctl_t;

  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic d;
  } lane_en_t;

  function automatic half_t half_split(input logic [15:0] h);
    half_t      o;
    logic [4:0] ex;
    logic [9:0] man;
    ex     = h[14:10];
    man    = h[9:0];
    o.sign = h[15];
    o.nan  = (ex == 5'h1F) && (man != 10'd0);
    o.inf  = (ex == 5'h1F) && (man == 10'd0);
    o.pay  = man;
    if (ex == 5'd0) begin
      o.mag = MagW'(man);
    end else begin
      o.mag = MagW'({1'b1, man}) << (ex - 5'd1);
    end
    return o;
  endfunction

  // Position of the leading one.
  function automatic logic [LeadW-1:0] lead_one(input logic [SumW-1:0] v);
    logic [LeadW-1:0] l;
    l = '0;
    for (int i = 0; i < SumW; i++) begin
      if (v[i]) l = LeadW'(i);
    end
    return l;
  endfunction

endpackage

>>> hdl/q41dq_seq.sv
// ----------------------------------------------------------------------------
// q41dq_seq
// Block holding register: decodes the halves and issues four groups.
// ----------------------------------------------------------------------------
module q41dq_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  q41dq_pkg::in_t       in_data_i,
  input  logic                 adv_i,
  output logic                 grp_valid_o,
  output logic [7:0][3:0]      nib_o,
  output q41dq_pkg::opnd_t     op_o,
  output q41dq_pkg::ctl_t      ctl_o
);

  logic             busy_q, busy_d;
  logic [1:0]       grp_q, grp_d;
  logic [63:0]      front_q, back_q;
  logic             row_q;
  q41dq_pkg::opnd_t op_q;
  logic             take;
  logic [63:0]      src;

  assign in_stall_o = busy_q && !((grp_q == q41dq_pkg::LastGroup) && adv_i);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    busy_d = busy_q;
    grp_d  = grp_q;
    if (busy_q && adv_i) begin
      grp_d = grp_q + 2'd1;
      if (grp_q == q41dq_pkg::LastGroup) busy_d = 1'b0;
    end
    if (take) begin
      busy_d = 1'b1;
      grp_d  = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      grp_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      grp_q  <= grp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      front_q <= in_data_i.quants_front;
      back_q  <= in_data_i.quants_back;
      row_q   <= in_data_i.row_end;
      op_q.s  <= q41dq_pkg::half_split(in_data_i.scale_half);
      op_q.m  <= q41dq_pkg::half_split(in_data_i.min_half);
    end
  end

  // Odd groups take the back bytes, upper groups the high nibbles.
  always_comb begin
    src = grp_q[0] ? back_q : front_q;
    if (grp_q[1]) src = src >> 4;
    for (int j = 0; j < 8; j++) begin
      nib_o[j] = src[j*8 +: 4] & q41dq_pkg::NibMask;
    end
  end

  assign grp_valid_o = busy_q;
  assign op_o        = op_q;
  assign ctl_o.grp   = grp_q;
  assign ctl_o.row   = row_q;

endmodule

>>> hdl/q41dq_lane.sv
// ----------------------------------------------------------------------------
// q41dq_lane
// One element lane: multiply, add, leading-one search, round to single.
// ----------------------------------------------------------------------------
module q41dq_lane (
  input  logic                 clk_i,
  input  q41dq_pkg::lane_en_t  en_i,
  input  logic [3:0]           q_i,
  input  q41dq_pkg::opnd_t     op_i,
  output logic [31:0]          value_o
);

  // stage A: exact product and special-case result
  logic [q41dq_pkg::ProdW-1:0] pm_q;
  logic [q41dq_pkg::MagW-1:0]  mm_a_q;
  logic                        ps_a_q, ms_a_q, sp_a_q;
  logic [31:0]                 sv_a_q;
  logic                        sp_d;
  logic [31:0]                 sv_d;
  logic [31:0]                 s_nan, m_nan;

  assign s_nan = {op_i.s.sign, 8'hFF, 1'b1, op_i.s.pay[8:0], 13'd0};
  assign m_nan = {op_i.m.sign, 8'hFF, 1'b1, op_i.m.pay[8:0], 13'd0};

  always_comb begin
    sp_d = 1'b1;
    sv_d = q41dq_pkg::DefaultNan;
    if (op_i.s.nan) begin
      sv_d = s_nan;
    end else if (op_i.s.inf && (q_i == 4'd0)) begin
      sv_d = q41dq_pkg::DefaultNan;
    end else if (op_i.m.nan) begin
      sv_d = m_nan;
    end else if (op_i.s.inf) begin
      if (op_i.m.inf && (op_i.m.sign != op_i.s.sign)) begin
        sv_d = q41dq_pkg::DefaultNan;
      end else begin
        sv_d = {op_i.s.sign, 8'hFF, 23'd0};
      end
    end else if (op_i.m.inf) begin
      sv_d = {op_i.m.sign, 8'hFF, 23'd0};
    end else begin
      sp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.a) begin
      pm_q   <= q41dq_pkg::ProdW'(op_i.s.mag) * q41dq_pkg::ProdW'(q_i);
      mm_a_q <= op_i.m.mag;
      ps_a_q <= op_i.s.sign;
      ms_a_q <= op_i.m.sign;
      sp_a_q <= sp_d;
      sv_a_q <= sv_d;
    end
  end

  // stage B: signed add as sign and magnitude
  logic [q41dq_pkg::SumW-1:0] pe, me;
  logic [q41dq_pkg::SumW-1:0] sum_d, sum_b_q;
  logic                       sg_d, sg_b_q, sp_b_q;
  logic [31:0]                sv_b_q;

  assign pe = q41dq_pkg::SumW'(pm_q);
  assign me = q41dq_pkg::SumW'(mm_a_q);

  always_comb begin
    if (ps_a_q == ms_a_q) begin
      sum_d = pe + me;
      sg_d  = ps_a_q;
    end else if (pe >= me) begin
      sum_d = pe - me;
      sg_d  = ps_a_q;
    end else begin
      sum_d = me - pe;
      sg_d  = ms_a_q;
    end
    // exact zero: negative only when both operands are negative zeros
    if (sum_d == '0) sg_d = ps_a_q & ms_a_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.b) begin
      sum_b_q <= sum_d;
      sg_b_q  <= sg_d;
      sp_b_q  <= sp_a_q;
      sv_b_q  <= sv_a_q;
    end
  end

  // stage C: leading-one position
  logic [q41dq_pkg::SumW-1:0]  sum_c_q;
  logic [q41dq_pkg::LeadW-1:0] lead_c_q;
  logic                        sg_c_q, sp_c_q;
  logic [31:0]                 sv_c_q;

  always_ff @(posedge clk_i) begin
    if (en_i.c) begin
      sum_c_q  <= sum_b_q;
      lead_c_q <= q41dq_pkg::lead_one(sum_b_q);
      sg_c_q   <= sg_b_q;
      sp_c_q   <= sp_b_q;
      sv_c_q   <= sv_b_q;
    end
  end

  // stage D: normalize and round to nearest even
  logic [q41dq_pkg::SumW-1:0] norm;
  logic [7:0]                 ex;
  logic                       guard, sticky, up;
  logic [30:0]                mag31;
  logic [31:0]                val_d, val_q;

  always_comb begin
    norm   = sum_c_q << (q41dq_pkg::LeadW'(q41dq_pkg::SumW - 1) - lead_c_q);
    ex     = 8'(lead_c_q) + q41dq_pkg::ExpOffset;
    guard  = norm[q41dq_pkg::SumW-25];
    sticky = |norm[q41dq_pkg::SumW-26:0];
    up     = guard && (sticky || norm[q41dq_pkg::SumW-24]);
    mag31  = {ex, norm[q41dq_pkg::SumW-2 -: 23]} + 31'(up);
    if (sp_c_q) begin
      val_d = sv_c_q;
    end else if (sum_c_q == '0) begin
      val_d = {sg_c_q, 31'd0};
    end else begin
      val_d = {sg_c_q, mag31};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.d) val_q <= val_d;
  end

  assign value_o = val_q;

endmodule

>>> hdl/q41_1_placeholder_never.sv
// ----------------------------------------------------------------------------
// q41dq_cnt
// Output group tracker: counts delivered groups of the current block.
// ----------------------------------------------------------------------------
module q41dq_cnt (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  output logic [1:0] grp_o
);

  logic [1:0] grp_q, grp_d;

  assign grp_d = fire_i ? grp_q + 2'd1 : grp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) grp_q <= 2'd0;
    else         grp_q <= grp_d;
  end

  assign grp_o = grp_q;

endmodule

>>> hdl/q4_1_block_dequantizer_core.sv
// ----------------------------------------------------------------------------
// q4_1_block_dequantizer_core
// Q4_1 block dequantizer: one block in, four groups of eight floats out.
// ----------------------------------------------------------------------------
// A block is taken in one transaction and leaves as four output transactions,
// one group of eight single-precision values each, in the order low nibbles
// of bytes 0..7, low nibbles of bytes 8..15, high nibbles of bytes 0..7,
// high nibbles of bytes 8..15. Each value is q*scale+min with the product
// exact and the sum rounded to nearest even; NaN and infinity follow IEEE
// rules. The block sustains one group per cycle while the output does not
// stall, and it takes the next block as the last group of the one before
// issues; the holding register feeds eight lanes. A block passes the
// holding register, product, add, leading-one search and round registers.
// Both sides may stall at any time; nothing is lost or repeated.
module q4_1_block_dequantizer_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  q41dq_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output q41dq_pkg::out_t   out_data_o
);

  // stage advance chain: a stage loads when it is empty or moving on
  logic                adv_a, adv_b, adv_c, adv_d;
  logic                va_q, vb_q, vc_q, vd_q;
  q41dq_pkg::ctl_t     ca_q, cb_q, cc_q, cd_q;
  q41dq_pkg::lane_en_t en;

  logic                grp_valid;
  logic [7:0][3:0]     nib;
  q41dq_pkg::opnd_t    op;
  q41dq_pkg::ctl_t     ctl;
  logic [7:0][31:0]    val;
  logic [1:0]          exp_grp;

  assign adv_d = !vd_q || !out_stall_i;
  assign adv_c = !vc_q || adv_d;
  assign adv_b = !vb_q || adv_c;
  assign adv_a = !va_q || adv_b;

  assign en.a = adv_a;
  assign en.b = adv_b;
  assign en.c = adv_c;
  assign en.d = adv_d;

  q41dq_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .adv_i       (adv_a),
    .grp_valid_o (grp_valid),
    .nib_o       (nib),
    .op_o        (op),
    .ctl_o       (ctl)
  );

  for (genvar j = 0; j < 8; j++) begin : g_lane
    q41dq_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .q_i     (nib[j]),
      .op_i    (op),
      .value_o (val[j])
    );
  end

  // valid bits travel with the lane data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (adv_a) va_q <= grp_valid;
      if (adv_b) vb_q <= va_q;
      if (adv_c) vc_q <= vb_q;
      if (adv_d) vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_a) ca_q <= ctl;
    if (adv_b) cb_q <= ca_q;
    if (adv_c) cc_q <= cb_q;
    if (adv_d) cd_q <= cc_q;
  end

  assign out_valid_o            = vd_q;
  assign out_data_o.value0      = val[0];
  assign out_data_o.value1      = val[1];
  assign out_data_o.value2      = val[2];
  assign out_data_o.value3      = val[3];
  assign out_data_o.value4      = val[4];
  assign out_data_o.value5      = val[5];
  assign out_data_o.value6      = val[6];
  assign out_data_o.value7      = val[7];
  assign out_data_o.group_index = cd_q.grp;
  assign out_data_o.block_done  = (cd_q.grp == q41dq_pkg::LastGroup);
  assign out_data_o.row_done    = (cd_q.grp == q41dq_pkg::LastGroup) && cd_q.row;

  // count delivered groups to check the output order
  q41dq_cnt u_cnt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (out_valid_o && !out_stall_i),
    .grp_o  (exp_grp)
  );

  // groups leave strictly in order 0, 1, 2, 3
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.group_index == exp_grp))
    else $error("output group out of order");

  // the holding register only takes a block once the previous one is issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (grp_valid && (ctl.grp == 2'd0)))
    else $error("block not issued from group zero");

  // a stalled output holds its group
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o.group_index)))
    else $error("stalled output group changed");

endmodule
